>>> hdl/csds_pkg.sv
// Shared types, register indexes and constants for the calibrated stick deadzone scaler.
package csds_pkg;

    localparam int RAW_W         = 12;
    localparam int FRAC_BITS_DEF = 15;
    localparam int CFG_IDX_W     = 4;
    localparam int CFG_DATA_W    = 12;
    localparam int OUT_W         = 16;
    localparam int QUOT_W        = 19;
    localparam int RECIP_SHIFT   = 19;

    localparam logic [RAW_W-1:0]  FALLBACK_LO = 12'd300;
    localparam logic [RAW_W-1:0]  FALLBACK_HI = 12'd3800;
    localparam logic [RAW_W-1:0]  RAW_MID     = 12'd2048;
    localparam logic [OUT_W-1:0]  OUT_FULL    = 16'd32767;
    localparam logic [OUT_W-1:0]  DZ_LIMIT    = 16'd2621;
    localparam logic [19:0]       GAIN_SCALE  = 20'd557039;
    localparam logic [15:0]       RECIP_10    = 16'd52429;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE_IS_LEFT = 4'd0,
        REG_UPRIGHT_MODE = 4'd1,
        REG_CENTER_X     = 4'd2,
        REG_CENTER_Y     = 4'd3,
        REG_MIN_X        = 4'd4,
        REG_MAX_X        = 4'd5,
        REG_MIN_Y        = 4'd6,
        REG_MAX_Y        = 4'd7
    } csds_reg_t;

    typedef struct packed {
        logic [7:0] stick_byte0;
        logic [7:0] stick_byte1;
        logic [7:0] stick_byte2;
        logic       report_too_short;
    } csds_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] axis_x_out;
        logic signed [OUT_W-1:0] axis_y_out;
        logic [RAW_W-1:0]        raw_x;
        logic [RAW_W-1:0]        raw_y;
    } csds_out_t;

    typedef struct packed {
        logic             too_short;
        logic [RAW_W-1:0] raw_x;
        logic [RAW_W-1:0] raw_y;
    } csds_side_t;

endpackage

>>> hdl/csds_lane.sv
// One axis lane: calibration select, pipelined long division and signed normalized result.
module csds_lane #(
    parameter int FRAC_BITS = csds_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [csds_pkg::RAW_W-1:0]    raw,
    input  logic [csds_pkg::RAW_W-1:0]    center,
    input  logic [csds_pkg::RAW_W-1:0]    min_val,
    input  logic [csds_pkg::RAW_W-1:0]    max_val,
    output logic signed [FRAC_BITS+1:0]   norm
);
    import csds_pkg::*;

    logic               fallback;
    logic [RAW_W-1:0]   center_clamped;
    logic [RAW_W-1:0]   lo_eff;
    logic [RAW_W-1:0]   hi_eff;
    logic [RAW_W-1:0]   c_eff;
    logic               at_or_above;
    logic [RAW_W-1:0]   dist_next;
    logic signed [RAW_W:0] span_next;
    logic               neg_next;

    logic               s0_neg_reg;
    logic [RAW_W-1:0]   s0_dist_reg;
    logic signed [RAW_W:0] s0_span_reg;

    logic               s1_zero_next;
    logic               s1_big_next;

    logic [RAW_W-1:0]     rem_reg  [0:FRAC_BITS];
    logic [FRAC_BITS-1:0] quot_reg [0:FRAC_BITS];
    logic [RAW_W-1:0]     span_reg [0:FRAC_BITS];
    logic                 neg_reg  [0:FRAC_BITS];
    logic                 zero_reg [0:FRAC_BITS];
    logic                 big_reg  [0:FRAC_BITS];

    logic [FRAC_BITS:0]         mag_next;
    logic signed [FRAC_BITS+1:0] norm_next;
    logic signed [FRAC_BITS+1:0] norm_reg;

    always_comb
    begin
        fallback = (min_val >= max_val);
        if (center < FALLBACK_LO)
        begin
            center_clamped = FALLBACK_LO;
        end
        else if (center > FALLBACK_HI)
        begin
            center_clamped = FALLBACK_HI;
        end
        else
        begin
            center_clamped = center;
        end
        lo_eff      = fallback ? FALLBACK_LO : min_val;
        hi_eff      = fallback ? FALLBACK_HI : max_val;
        c_eff       = fallback ? center_clamped : center;
        at_or_above = (raw >= c_eff);
        neg_next    = !at_or_above;
        dist_next   = at_or_above ? (raw - c_eff) : (c_eff - raw);
        span_next   = at_or_above ? ($signed({1'b0, hi_eff}) - $signed({1'b0, c_eff}))
                                  : ($signed({1'b0, c_eff}) - $signed({1'b0, lo_eff}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_neg_reg  <= neg_next;
            s0_dist_reg <= dist_next;
            s0_span_reg <= span_next;
        end
    end

    always_comb
    begin
        s1_zero_next = s0_span_reg[RAW_W] || (s0_span_reg == '0);
        s1_big_next  = !s1_zero_next && (s0_dist_reg >= s0_span_reg[RAW_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= s0_dist_reg;
            quot_reg[0] <= '0;
            span_reg[0] <= s0_span_reg[RAW_W-1:0];
            neg_reg[0]  <= s0_neg_reg;
            zero_reg[0] <= s1_zero_next;
            big_reg[0]  <= s1_big_next;
        end
    end

    // Each stage produces one quotient bit, most significant first.
    for (genvar k = 1; k <= FRAC_BITS; k++)
    begin : g_div
        logic [RAW_W:0]     trial;
        logic               take;
        logic [RAW_W-1:0]   rem_next;
        logic [FRAC_BITS-1:0] quot_next;

        always_comb
        begin
            trial     = {rem_reg[k-1], 1'b0};
            take      = (trial >= {1'b0, span_reg[k-1]});
            rem_next  = take ? RAW_W'(trial - {1'b0, span_reg[k-1]}) : trial[RAW_W-1:0];
            quot_next = {quot_reg[k-1][FRAC_BITS-2:0], take};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                quot_reg[k] <= quot_next;
                span_reg[k] <= span_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                big_reg[k]  <= big_reg[k-1];
            end
        end
    end

    always_comb
    begin
        if (zero_reg[FRAC_BITS])
        begin
            mag_next = '0;
        end
        else if (big_reg[FRAC_BITS])
        begin
            mag_next = (FRAC_BITS+1)'(1) << FRAC_BITS;
        end
        else
        begin
            mag_next = {1'b0, quot_reg[FRAC_BITS]};
        end
        norm_next = neg_reg[FRAC_BITS] ? -$signed({1'b0, mag_next})
                                       : $signed({1'b0, mag_next});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            norm_reg <= norm_next;
        end
    end

    assign norm = norm_reg;

endmodule

>>> hdl/csds_merge.sv
// Merging stage: rotation, joint deadzone, gain with saturation and output scaling.
module csds_merge #(
    parameter int FRAC_BITS = csds_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               en,
    input  logic                               side_is_left,
    input  logic                               upright_mode,
    input  logic signed [FRAC_BITS+1:0]        norm_x,
    input  logic signed [FRAC_BITS+1:0]        norm_y,
    output logic signed [csds_pkg::OUT_W-1:0]  axis_x,
    output logic signed [csds_pkg::OUT_W-1:0]  axis_y
);
    import csds_pkg::*;

    localparam int SAT_LIMIT = 10 * (2 ** FRAC_BITS);
    localparam int P_W       = FRAC_BITS + 21;
    localparam int PROD_W    = QUOT_W + 16;

    logic signed [FRAC_BITS+1:0] rot_x;
    logic signed [FRAC_BITS+1:0] rot_y;
    logic [FRAC_BITS+1:0]        abs_x;
    logic [FRAC_BITS+1:0]        abs_y;
    logic [OUT_W-1:0]            dz_x;
    logic [OUT_W-1:0]            dz_y;
    logic                        dead_next;

    logic [FRAC_BITS:0] m0_mag_x_reg;
    logic [FRAC_BITS:0] m0_mag_y_reg;
    logic               m0_neg_x_reg;
    logic               m0_neg_y_reg;
    logic               m0_dead_reg;

    logic [FRAC_BITS+5:0] gain_x;
    logic [FRAC_BITS+5:0] gain_y;
    logic [P_W-1:0]       m1_p_x_reg;
    logic [P_W-1:0]       m1_p_y_reg;
    logic                 m1_sat_x_reg;
    logic                 m1_sat_y_reg;
    logic                 m1_neg_x_reg;
    logic                 m1_neg_y_reg;
    logic                 m1_dead_reg;

    logic [QUOT_W-1:0]  quot_x;
    logic [QUOT_W-1:0]  quot_y;
    logic [PROD_W-1:0]  m2_prod_x_reg;
    logic [PROD_W-1:0]  m2_prod_y_reg;
    logic [QUOT_W-1:0]  m2_quot_x_reg;
    logic [QUOT_W-1:0]  m2_quot_y_reg;
    logic               m2_sat_x_reg;
    logic               m2_sat_y_reg;
    logic               m2_neg_x_reg;
    logic               m2_neg_y_reg;
    logic               m2_dead_reg;

    logic [OUT_W-1:0] est_x;
    logic [OUT_W-1:0] est_y;
    logic [19:0]      back_x;
    logic [19:0]      back_y;
    logic [OUT_W-1:0] mag_x;
    logic [OUT_W-1:0] mag_y;

    always_comb
    begin
        if (upright_mode)
        begin
            rot_x = norm_x;
            rot_y = norm_y;
        end
        else if (side_is_left)
        begin
            rot_x = -norm_y;
            rot_y = norm_x;
        end
        else
        begin
            rot_x = norm_y;
            rot_y = -norm_x;
        end
        abs_x     = rot_x[FRAC_BITS+1] ? (FRAC_BITS+2)'(0) - rot_x : rot_x;
        abs_y     = rot_y[FRAC_BITS+1] ? (FRAC_BITS+2)'(0) - rot_y : rot_y;
        dz_x      = OUT_W'(abs_x[FRAC_BITS:0]) << (15 - FRAC_BITS);
        dz_y      = OUT_W'(abs_y[FRAC_BITS:0]) << (15 - FRAC_BITS);
        dead_next = (dz_x < DZ_LIMIT) && (dz_y < DZ_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m0_mag_x_reg <= abs_x[FRAC_BITS:0];
            m0_mag_y_reg <= abs_y[FRAC_BITS:0];
            m0_neg_x_reg <= rot_x[FRAC_BITS+1];
            // The vertical output is the negated gain result.
            m0_neg_y_reg <= !rot_y[FRAC_BITS+1];
            m0_dead_reg  <= dead_next;
        end
    end

    always_comb
    begin
        gain_x = (FRAC_BITS+6)'({m0_mag_x_reg, 4'b0000}) + (FRAC_BITS+6)'(m0_mag_x_reg);
        gain_y = (FRAC_BITS+6)'({m0_mag_y_reg, 4'b0000}) + (FRAC_BITS+6)'(m0_mag_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_p_x_reg   <= P_W'(m0_mag_x_reg) * P_W'(GAIN_SCALE);
            m1_p_y_reg   <= P_W'(m0_mag_y_reg) * P_W'(GAIN_SCALE);
            m1_sat_x_reg <= (gain_x > (FRAC_BITS+6)'(SAT_LIMIT));
            m1_sat_y_reg <= (gain_y > (FRAC_BITS+6)'(SAT_LIMIT));
            m1_neg_x_reg <= m0_neg_x_reg;
            m1_neg_y_reg <= m0_neg_y_reg;
            m1_dead_reg  <= m0_dead_reg;
        end
    end

    always_comb
    begin
        quot_x = m1_p_x_reg[FRAC_BITS+QUOT_W-1:FRAC_BITS];
        quot_y = m1_p_y_reg[FRAC_BITS+QUOT_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m2_prod_x_reg <= PROD_W'(quot_x) * PROD_W'(RECIP_10);
            m2_prod_y_reg <= PROD_W'(quot_y) * PROD_W'(RECIP_10);
            m2_quot_x_reg <= quot_x;
            m2_quot_y_reg <= quot_y;
            m2_sat_x_reg  <= m1_sat_x_reg;
            m2_sat_y_reg  <= m1_sat_y_reg;
            m2_neg_x_reg  <= m1_neg_x_reg;
            m2_neg_y_reg  <= m1_neg_y_reg;
            m2_dead_reg   <= m1_dead_reg;
        end
    end

    // The reciprocal estimate of a tenth is never low and at most one too high.
    always_comb
    begin
        est_x  = m2_prod_x_reg[RECIP_SHIFT+OUT_W-1:RECIP_SHIFT];
        est_y  = m2_prod_y_reg[RECIP_SHIFT+OUT_W-1:RECIP_SHIFT];
        back_x = 20'({est_x, 3'b000}) + 20'({est_x, 1'b0});
        back_y = 20'({est_y, 3'b000}) + 20'({est_y, 1'b0});
        mag_x  = (back_x > 20'(m2_quot_x_reg)) ? est_x - 16'd1 : est_x;
        mag_y  = (back_y > 20'(m2_quot_y_reg)) ? est_y - 16'd1 : est_y;
        if (m2_sat_x_reg)
        begin
            mag_x = OUT_FULL;
        end
        if (m2_sat_y_reg)
        begin
            mag_y = OUT_FULL;
        end
        if (m2_dead_reg)
        begin
            axis_x = '0;
            axis_y = '0;
        end
        else
        begin
            axis_x = m2_neg_x_reg ? -$signed(mag_x) : $signed(mag_x);
            axis_y = m2_neg_y_reg ? -$signed(mag_y) : $signed(mag_y);
        end
    end

endmodule

>>> hdl/calibrated_stick_deadzone_scaler_top.sv
// Top level of the calibrated stick deadzone scaler: registers, lanes, merge and output skid.
// Throughput: one request per cycle while the skid entry is empty; each axis lane
// divides with FRAC_BITS pipelined steps.
// A two-entry output (register plus skid) lets requests keep entering while a result waits.
// Reset: configuration returns to its defaults and the pipeline and output are emptied.
module calibrated_stick_deadzone_scaler_top #(
    parameter int FRAC_BITS = csds_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  csds_pkg::csds_in_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output csds_pkg::csds_out_t                out_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csds_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import csds_pkg::*;

    localparam int NSTG = FRAC_BITS + 6;

    logic             side_is_left_reg;
    logic             upright_mode_reg;
    logic [RAW_W-1:0] center_x_reg;
    logic [RAW_W-1:0] center_y_reg;
    logic [RAW_W-1:0] min_x_reg;
    logic [RAW_W-1:0] max_x_reg;
    logic [RAW_W-1:0] min_y_reg;
    logic [RAW_W-1:0] max_y_reg;

    logic             en;
    logic             accept;
    logic [RAW_W-1:0] raw_x_in;
    logic [RAW_W-1:0] raw_y_in;
    csds_side_t       side_next;

    logic [NSTG-1:0]  valid_reg;
    csds_side_t       side_reg [0:NSTG-1];

    logic signed [FRAC_BITS+1:0] norm_x;
    logic signed [FRAC_BITS+1:0] norm_y;
    logic signed [OUT_W-1:0]     axis_x;
    logic signed [OUT_W-1:0]     axis_y;

    csds_out_t result;
    logic      leaving;
    logic      take;
    logic      out_valid_reg;
    csds_out_t out_reg;
    logic      skid_valid_reg;
    csds_out_t skid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_is_left_reg <= 1'b1;
            upright_mode_reg <= 1'b1;
            center_x_reg     <= RAW_MID;
            center_y_reg     <= RAW_MID;
            min_x_reg        <= '0;
            max_x_reg        <= '1;
            min_y_reg        <= '0;
            max_y_reg        <= '1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SIDE_IS_LEFT: side_is_left_reg <= cfg_data[0];
                REG_UPRIGHT_MODE: upright_mode_reg <= cfg_data[0];
                REG_CENTER_X:     center_x_reg     <= cfg_data;
                REG_CENTER_Y:     center_y_reg     <= cfg_data;
                REG_MIN_X:        min_x_reg        <= cfg_data;
                REG_MAX_X:        max_x_reg        <= cfg_data;
                REG_MIN_Y:        min_y_reg        <= cfg_data;
                REG_MAX_Y:        max_y_reg        <= cfg_data;
                default:          ;
            endcase
        end
    end

    // The whole pipeline moves together; it holds only while the skid entry is occupied.
    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && en;

    always_comb
    begin
        raw_x_in            = {in_data.stick_byte1[3:0], in_data.stick_byte0};
        raw_y_in            = {in_data.stick_byte2, in_data.stick_byte1[7:4]};
        side_next.too_short = in_data.report_too_short;
        side_next.raw_x     = in_data.report_too_short ? RAW_MID : raw_x_in;
        side_next.raw_y     = in_data.report_too_short ? RAW_MID : raw_y_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_next;
            for (int i = 1; i < NSTG; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    csds_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_x (
        .clk     (clk),
        .en      (en),
        .raw     (raw_x_in),
        .center  (center_x_reg),
        .min_val (min_x_reg),
        .max_val (max_x_reg),
        .norm    (norm_x)
    );

    csds_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_lane_y (
        .clk     (clk),
        .en      (en),
        .raw     (raw_y_in),
        .center  (center_y_reg),
        .min_val (min_y_reg),
        .max_val (max_y_reg),
        .norm    (norm_y)
    );

    csds_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .clk          (clk),
        .en           (en),
        .side_is_left (side_is_left_reg),
        .upright_mode (upright_mode_reg),
        .norm_x       (norm_x),
        .norm_y       (norm_y),
        .axis_x       (axis_x),
        .axis_y       (axis_y)
    );

    always_comb
    begin
        result.axis_x_out = side_reg[NSTG-1].too_short ? '0 : axis_x;
        result.axis_y_out = side_reg[NSTG-1].too_short ? '0 : axis_y;
        result.raw_x      = side_reg[NSTG-1].raw_x;
        result.raw_y      = side_reg[NSTG-1].raw_y;
    end

    assign leaving = en && valid_reg[NSTG-1];
    assign take    = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (leaving)
        begin
            if (out_valid_reg && !take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (leaving)
        begin
            if (out_valid_reg && !take)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

>>> hdl/csds_checker.sv
// Port-level checker for the calibrated stick deadzone scaler and its bind to the top level.
module csds_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input csds_pkg::csds_out_t  out_data
);
    import csds_pkg::*;

    // A stalled result stays and keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or vanished");

    // Requests are only held back once a result was stalled at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stalled without a stalled result");

    // The skid entry is only occupied behind a full output register.
    a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty output");

    // Scaled outputs stay symmetric and never reach the most negative code.
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.axis_x_out != 16'sh8000) && (out_data.axis_y_out != 16'sh8000))
        else $error("axis output outside the symmetric range");

endmodule

bind calibrated_stick_deadzone_scaler_top csds_checker u_csds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> verif/stick_scaler_checker.sv
// Checker for the stick scaler: tracks the register file, predicts each sample and compares.
`timescale 1ns / 100ps

module stick_scaler_checker #(
    parameter int FRAC_BITS = csds_pkg::FRAC_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  csds_pkg::csds_in_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  csds_pkg::csds_out_t             out_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [csds_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [csds_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              pending
);
    import csds_pkg::*;

    localparam longint GAIN_NUM  = 17;
    localparam longint GAIN_DEN  = 10;
    localparam int     PRINT_CAP = 40;

    logic             side_left;
    logic             upright;
    logic [RAW_W-1:0] ctr_x;
    logic [RAW_W-1:0] ctr_y;
    logic [RAW_W-1:0] lo_x;
    logic [RAW_W-1:0] hi_x;
    logic [RAW_W-1:0] lo_y;
    logic [RAW_W-1:0] hi_y;

    csds_out_t predicted_axes_q[$];

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
        begin
            $display("MISMATCH at %0t: %s", $realtime, msg);
        end
        mismatches++;
    endtask

    task automatic enqueue_expected(input csds_out_t item);
        predicted_axes_q.insert(predicted_axes_q.size(), item);
    endtask

    function automatic longint normalize_axis(longint raw, longint c, longint lo, longint hi);
        longint one;
        longint v;
        longint span;
        one = longint'(1) << FRAC_BITS;
        v = 0;
        if (lo >= hi)
        begin
            lo = longint'(FALLBACK_LO);
            hi = longint'(FALLBACK_HI);
            if (c < lo)
            begin
                c = lo;
            end
            if (c > hi)
            begin
                c = hi;
            end
        end
        if (raw >= c)
        begin
            span = hi - c;
            if (span > 0)
            begin
                v = ((raw - c) << FRAC_BITS) / span;
            end
        end
        else
        begin
            span = c - lo;
            if (span > 0)
            begin
                v = -(((c - raw) << FRAC_BITS) / span);
            end
        end
        if (v > one)
        begin
            v = one;
        end
        if (v < -one)
        begin
            v = -one;
        end
        return v;
    endfunction

    function automatic bit in_dead_band(longint q);
        longint mag;
        mag = (q < 0) ? -q : q;
        return (mag << (15 - FRAC_BITS)) < longint'(DZ_LIMIT);
    endfunction

    function automatic longint gain_scale(longint q);
        longint den;
        longint t;
        longint mag;
        den = GAIN_DEN << FRAC_BITS;
        t = q * GAIN_NUM;
        if (t > den)
        begin
            t = den;
        end
        if (t < -den)
        begin
            t = -den;
        end
        mag = (((t < 0) ? -t : t) * longint'(OUT_FULL)) / den;
        return (t < 0) ? -mag : mag;
    endfunction

    function automatic csds_out_t scale_sample(csds_in_t d);
        csds_out_t        r;
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        longint           x;
        longint           y;
        longint           tx;
        longint           ox;
        longint           oy;
        r = '0;
        if (d.report_too_short)
        begin
            r.raw_x = RAW_MID;
            r.raw_y = RAW_MID;
            return r;
        end
        rx = {d.stick_byte1[3:0], d.stick_byte0};
        ry = {d.stick_byte2, d.stick_byte1[7:4]};
        x = normalize_axis(longint'(rx), longint'(ctr_x), longint'(lo_x), longint'(hi_x));
        y = normalize_axis(longint'(ry), longint'(ctr_y), longint'(lo_y), longint'(hi_y));
        if (!upright)
        begin
            tx = x;
            x = side_left ? -y : y;
            y = side_left ? tx : -tx;
        end
        ox = 0;
        oy = 0;
        if (!(in_dead_band(x) && in_dead_band(y)))
        begin
            ox = gain_scale(x);
            oy = -gain_scale(y);
        end
        r.axis_x_out = ox[OUT_W-1:0];
        r.axis_y_out = oy[OUT_W-1:0];
        r.raw_x = rx;
        r.raw_y = ry;
        return r;
    endfunction

    task automatic check_result(input csds_out_t got);
        csds_out_t want;
        if (predicted_axes_q.size() == 0)
        begin
            report_mismatch("result arrived with no request outstanding");
            return;
        end
        want = predicted_axes_q.pop_front();
        if (got.axis_x_out !== want.axis_x_out)
        begin
            report_mismatch($sformatf("axis_x_out got %0d expected %0d (raw %0d, %0d)",
                got.axis_x_out, want.axis_x_out, want.raw_x, want.raw_y));
        end
        if (got.axis_y_out !== want.axis_y_out)
        begin
            report_mismatch($sformatf("axis_y_out got %0d expected %0d (raw %0d, %0d)",
                got.axis_y_out, want.axis_y_out, want.raw_x, want.raw_y));
        end
        if (got.raw_x !== want.raw_x)
        begin
            report_mismatch($sformatf("raw_x got %0d expected %0d", got.raw_x, want.raw_x));
        end
        if (got.raw_y !== want.raw_y)
        begin
            report_mismatch($sformatf("raw_y got %0d expected %0d", got.raw_y, want.raw_y));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_left = 1'b1;
            upright = 1'b1;
            ctr_x = RAW_MID;
            ctr_y = RAW_MID;
            lo_x = '0;
            hi_x = '1;
            lo_y = '0;
            hi_y = '1;
            predicted_axes_q.delete();
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_result(out_data);
            end
            if (in_valid && !in_stall)
            begin
                enqueue_expected(scale_sample(in_data));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SIDE_IS_LEFT: side_left = cfg_data[0];
                    REG_UPRIGHT_MODE: upright = cfg_data[0];
                    REG_CENTER_X:     ctr_x = cfg_data;
                    REG_CENTER_Y:     ctr_y = cfg_data;
                    REG_MIN_X:        lo_x = cfg_data;
                    REG_MAX_X:        hi_x = cfg_data;
                    REG_MIN_Y:        lo_y = cfg_data;
                    REG_MAX_Y:        hi_y = cfg_data;
                    default:          ;
                endcase
            end
            pending <= predicted_axes_q.size();
        end
    end

endmodule

>>> verif/calibrated_stick_deadzone_scaler_top_test.sv
// Testbench top for the stick scaler: stimulus, register setup, flow control and verdict.
`timescale 1ns / 100ps

module calibrated_stick_deadzone_scaler_top_test;
    import csds_pkg::*;

    localparam int LATENCY        = FRAC_BITS_DEF + 7;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SEGMENTS       = 9;
    localparam int SEG_ITEMS      = 97;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'd15;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    csds_in_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    csds_out_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    pending;

    int               tx_idle_pct = 0;
    int               rx_idle_pct = 0;
    int               hold_requests = 0;
    int               holds_done = 0;
    int               quiet_cycles = 0;
    int               samples_sent = 0;
    int               short_sent = 0;
    int               reg_writes = 0;
    int               settings_used = 0;
    logic [RAW_W-1:0] cur_cx = RAW_MID;
    logic [RAW_W-1:0] cur_cy = RAW_MID;
    logic             moved;

    calibrated_stick_deadzone_scaler_top dut (.*);

    stick_scaler_checker u_scaler_checker (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    assign moved = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                   (cfg_valid && cfg_ready);

    always @(posedge clk)
    begin
        if (moved)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done != hold_requests)
            begin
                holds_done = holds_done + 1;
                for (n = 0; n < HOLD_CYCLES; n++)
                begin
                    out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    task automatic send_raw(input logic [RAW_W-1:0] rx, input logic [RAW_W-1:0] ry,
                            input logic short_rep);
        csds_in_t d;
        d.stick_byte0 = rx[7:0];
        d.stick_byte1 = {ry[3:0], rx[11:8]};
        d.stick_byte2 = ry[11:4];
        d.report_too_short = short_rep;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        samples_sent++;
        if (short_rep)
        begin
            short_sent++;
        end
    endtask

    function automatic logic [RAW_W-1:0] aim(input int c, input int spread);
        int v;
        v = c + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > 4095)
        begin
            v = 4095;
        end
        return v[RAW_W-1:0];
    endfunction

    function automatic logic [RAW_W-1:0] near_limit();
        if ($urandom_range(0, 1))
        begin
            return RAW_W'($urandom_range(0, 40));
        end
        return RAW_W'(4095 - $urandom_range(0, 40));
    endfunction

    task automatic send_random();
        int               r;
        logic [RAW_W-1:0] rx;
        logic [RAW_W-1:0] ry;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            rx = RAW_W'($urandom_range(0, 4095));
            ry = RAW_W'($urandom_range(0, 4095));
        end
        else if (r < 80)
        begin
            rx = aim(cur_cx, 300);
            ry = aim(cur_cy, 300);
        end
        else
        begin
            rx = near_limit();
            ry = near_limit();
        end
        send_raw(rx, ry, $urandom_range(0, 99) < 8);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        reg_writes++;
        if (idx == REG_CENTER_X)
        begin
            cur_cx = val;
        end
        if (idx == REG_CENTER_Y)
        begin
            cur_cy = val;
        end
    endtask

    task automatic random_axis(input logic [CFG_IDX_W-1:0] lo_idx,
                               input logic [CFG_IDX_W-1:0] hi_idx,
                               input logic [CFG_IDX_W-1:0] c_idx);
        if ($urandom_range(0, 1))
        begin
            write_reg(lo_idx, CFG_DATA_W'($urandom_range(100, 700)));
            write_reg(hi_idx, CFG_DATA_W'($urandom_range(3300, 4000)));
            write_reg(c_idx, CFG_DATA_W'($urandom_range(1700, 2400)));
        end
        else
        begin
            write_reg(lo_idx, CFG_DATA_W'($urandom_range(0, 4095)));
            write_reg(hi_idx, CFG_DATA_W'($urandom_range(0, 4095)));
            write_reg(c_idx, CFG_DATA_W'($urandom_range(0, 4095)));
        end
    endtask

    task automatic load_setting(input int seg);
        case (seg)
            0:
            begin
                write_reg(REG_SIDE_IS_LEFT, 12'hFFF);
                write_reg(REG_UPRIGHT_MODE, 12'hFFE);
                write_reg(REG_SPARE, 12'h5A5);
            end
            1:
            begin
                write_reg(REG_SIDE_IS_LEFT, 12'h002);
            end
            2:
            begin
                write_reg(REG_UPRIGHT_MODE, 12'h001);
                write_reg(REG_MIN_X, 12'd4095);
                write_reg(REG_MAX_X, 12'd0);
                write_reg(REG_CENTER_X, 12'd0);
                write_reg(REG_MIN_Y, 12'd2000);
                write_reg(REG_MAX_Y, 12'd2000);
                write_reg(REG_CENTER_Y, 12'd4095);
            end
            3:
            begin
                write_reg(REG_SIDE_IS_LEFT, 12'h001);
                write_reg(REG_UPRIGHT_MODE, 12'h000);
                write_reg(REG_MIN_X, 12'd0);
                write_reg(REG_MAX_X, 12'd4095);
                write_reg(REG_CENTER_X, 12'd0);
                write_reg(REG_MIN_Y, 12'd0);
                write_reg(REG_MAX_Y, 12'd4095);
                write_reg(REG_CENTER_Y, 12'd4095);
            end
            4:
            begin
                write_reg(REG_SIDE_IS_LEFT, 12'h000);
                write_reg(REG_MIN_X, 12'd1000);
                write_reg(REG_MAX_X, 12'd2000);
                write_reg(REG_CENTER_X, 12'd3000);
                write_reg(REG_MIN_Y, 12'd1000);
                write_reg(REG_MAX_Y, 12'd3000);
                write_reg(REG_CENTER_Y, 12'd500);
            end
            default:
            begin
                write_reg(REG_SIDE_IS_LEFT, CFG_DATA_W'($urandom_range(0, 4095)));
                write_reg(REG_UPRIGHT_MODE, CFG_DATA_W'($urandom_range(0, 4095)));
                random_axis(REG_MIN_X, REG_MAX_X, REG_CENTER_X);
                random_axis(REG_MIN_Y, REG_MAX_Y, REG_CENTER_Y);
            end
        endcase
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic wait_empty();
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (pending != 0);
    endtask

    task automatic settle();
        wait_empty();
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    initial
    begin
        int seg;
        int i;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_raw(12'd0, 12'd0, 1'b0);
        send_raw(12'd4095, 12'd4095, 1'b0);
        send_raw(12'd2048, 12'd2048, 1'b0);
        send_raw(12'd4095, 12'd0, 1'b0);
        send_raw(12'd0, 12'd4095, 1'b0);
        send_raw(12'd2211, 12'd2048, 1'b0);
        send_raw(12'd2212, 12'd2048, 1'b0);
        send_raw(12'd1885, 12'd2048, 1'b0);
        send_raw(12'd1884, 12'd2048, 1'b0);
        send_raw(12'd2048, 12'd2211, 1'b0);
        send_raw(12'd2048, 12'd1884, 1'b0);
        send_raw(12'd2211, 12'd1885, 1'b0);
        send_raw(12'd3252, 12'd3253, 1'b0);
        send_raw(12'd2048, 12'd3000, 1'b0);
        send_raw(12'd4095, 12'd4095, 1'b1);
        send_raw(12'd0, 12'd0, 1'b1);
        settle();

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < 3)
            begin
                tx_idle_pct = 17;
                rx_idle_pct = 85;
            end
            else if (seg < 6)
            begin
                tx_idle_pct = 85;
                rx_idle_pct = 17;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            load_setting(seg);
            if (seg == 6)
            begin
                hold_requests++;
            end
            send_raw(12'd0, 12'd0, 1'b0);
            send_raw(12'd4095, 12'd4095, 1'b0);
            send_raw(cur_cx, cur_cy, 1'b0);
            for (i = 0; i < SEG_ITEMS; i++)
            begin
                if (seg == 4 && i == SEG_ITEMS / 2)
                begin
                    wait_empty();
                end
                send_random();
            end
            settle();
        end

        $display("Covered %0d stick samples (%0d short reports) over %0d settings, %0d writes.",
            samples_sent, short_sent, settings_used + 1, reg_writes);
        $display("Included sideways rotation, fallback limits, empty spans and a long hold-off.");
        if (mismatches == 0 && pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
